@@ sv/mcl_pkg.sv @@
// ----------------------------------------------------------------------------
// mcl_pkg: shared definitions for the 3D Morton level codec
// Field widths, request codes and the level mask helpers used by all units.
// ----------------------------------------------------------------------------
`default_nettype none

package mcl_pkg;

	localparam int CODE_W        = 64;
	localparam int IDX_W         = 21;
	localparam int LVL_W         = 5;
	localparam int REQ_W         = 2;
	localparam int CNT_W         = 7;
	localparam int MAX_LEVEL_DEF = 21;
	localparam int CODE_LEVELS   = 21;

	localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DECODE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PARENT = 2'd2;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LVL_W-1:0]  lvl_t;
	typedef logic [REQ_W-1:0]  req_t;

	typedef struct packed {
		code_t code;
		idx_t  idx_i;
		idx_t  idx_j;
		idx_t  idx_k;
		lvl_t  level;
	} result_t;

	function automatic lvl_t clamp_level(input lvl_t v, input lvl_t max_lvl);
		return (v > max_lvl) ? max_lvl : v;
	endfunction

	// Distance from the top Morton bit to bit 64, that is 64 - 3L.
	function automatic logic [CNT_W-1:0] top_shift(input lvl_t lvl);
		return 7'd64 - (7'd3 * {2'b00, lvl});
	endfunction

	// The 63 - 3L trailing ones that mark level L.
	function automatic code_t level_flag(input lvl_t lvl);
		logic [CNT_W-1:0] sh;
		sh = 7'd63 - (7'd3 * {2'b00, lvl});
		return ~({CODE_W{1'b1}} << sh);
	endfunction

	// Ones over the top 3L bits; empty at level zero.
	function automatic code_t top_mask(input lvl_t lvl);
		return {CODE_W{1'b1}} << top_shift(lvl);
	endfunction

endpackage

`default_nettype wire

@@ sv/mcl_encode.sv @@
// ----------------------------------------------------------------------------
// mcl_encode: index to grid code encoder
// Interleaves the three indices and places them above the level flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_encode
	import mcl_pkg::*;
#(
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  idx_t  coord_i,
	input  idx_t  coord_j,
	input  idx_t  coord_k,
	input  lvl_t  cell_level,
	output code_t code,
	output lvl_t  level
);

	lvl_t  lvl;
	code_t morton;

	always_comb begin
		lvl    = clamp_level(cell_level, LVL_W'(MAX_LEVEL));
		morton = '0;
		for (int b = 0; b < IDX_W; b++) begin
			morton[3*b]     = coord_i[b];
			morton[3*b + 1] = coord_j[b];
			morton[3*b + 2] = coord_k[b];
		end
	end

	// Triples at or above the level are shifted out of the word.
	assign code  = (morton << top_shift(lvl)) | level_flag(lvl);
	assign level = lvl;

endmodule

`default_nettype wire

@@ sv/mcl_decode.sv @@
// ----------------------------------------------------------------------------
// mcl_decode: grid code to index decoder
// Finds the level from the trailing ones and de-interleaves the indices.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_decode
	import mcl_pkg::*;
#(
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  code_t code_in,
	output idx_t  idx_i,
	output idx_t  idx_j,
	output idx_t  idx_k,
	output lvl_t  level
);

	code_t            lowest_zero;
	logic [CNT_W-1:0] ones;
	logic [12:0]      ones_x43;
	lvl_t             third;
	lvl_t             lvl;
	code_t            morton;

	always_comb begin
		lowest_zero = ~code_in & (code_in + 64'd1);
		ones        = {&code_in, 6'd0};
		for (int n = 0; n < CODE_W; n++) begin
			if (lowest_zero[n]) begin
				ones = ones | CNT_W'(n);
			end
		end
		// Division by three through the reciprocal 43/128, exact for counts up to 64.
		ones_x43 = {6'd0, ones} * 13'd43;
		third    = ones_x43[11:7];
		lvl      = clamp_level(LVL_W'(CODE_LEVELS) - third, LVL_W'(MAX_LEVEL));
		morton   = code_in >> top_shift(lvl);
		for (int b = 0; b < IDX_W; b++) begin
			idx_i[b] = morton[3*b];
			idx_j[b] = morton[3*b + 1];
			idx_k[b] = morton[3*b + 2];
		end
	end

	assign level = lvl;

endmodule

`default_nettype wire

@@ sv/mcl_parent.sv @@
// ----------------------------------------------------------------------------
// mcl_parent: parent cell code generator
// Keeps the Morton bits of the target level and appends its flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_parent
	import mcl_pkg::*;
#(
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  code_t code_in,
	input  lvl_t  parent_level,
	output code_t code,
	output lvl_t  level
);

	lvl_t lvl;

	assign lvl   = clamp_level(parent_level, LVL_W'(MAX_LEVEL));
	assign code  = (code_in & top_mask(lvl)) | level_flag(lvl);
	assign level = lvl;

endmodule

`default_nettype wire

@@ sv/morton_code_3d_level_codec.sv @@
// ----------------------------------------------------------------------------
// morton_code_3d_level_codec: 3D Morton grid code codec with level suffix
// Encodes indices, decodes codes and forms parent codes, one request a cycle.
// ----------------------------------------------------------------------------
// A request is captured in the input register, passes the encode, decode and
// parent logic, and is held in the result register until it is taken.
// Throughput is one request per cycle while out_ready is not stalling it, set by
// the single pass of logic between the input register and the result register.
// Reset clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module morton_code_3d_level_codec
	import mcl_pkg::*;
#(
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	input  req_t  req_type,
	input  idx_t  coord_i,
	input  idx_t  coord_j,
	input  idx_t  coord_k,
	input  lvl_t  cell_level,
	input  code_t code_in,
	input  lvl_t  parent_level,
	output logic  out_valid,
	input  wire   out_ready,
	output code_t code_out,
	output idx_t  out_i,
	output idx_t  out_j,
	output idx_t  out_k,
	output lvl_t  out_level
);

	logic  valid_s1;
	req_t  req_s1;
	idx_t  coord_i_s1;
	idx_t  coord_j_s1;
	idx_t  coord_k_s1;
	lvl_t  cell_level_s1;
	code_t code_in_s1;
	lvl_t  parent_level_s1;

	logic    valid_s2;
	result_t result_s2;

	code_t   enc_code;
	lvl_t    enc_level;
	idx_t    dec_i;
	idx_t    dec_j;
	idx_t    dec_k;
	lvl_t    dec_level;
	code_t   par_code;
	lvl_t    par_level;
	result_t result;

	logic advance_s2;
	logic advance_s1;

	assign advance_s2 = !valid_s2 || out_ready;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign in_ready   = advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && advance_s1) begin
			req_s1          <= req_type;
			coord_i_s1      <= coord_i;
			coord_j_s1      <= coord_j;
			coord_k_s1      <= coord_k;
			cell_level_s1   <= cell_level;
			code_in_s1      <= code_in;
			parent_level_s1 <= parent_level;
		end
	end

	mcl_encode #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_encode (
		.coord_i   (coord_i_s1),
		.coord_j   (coord_j_s1),
		.coord_k   (coord_k_s1),
		.cell_level(cell_level_s1),
		.code      (enc_code),
		.level     (enc_level)
	);

	mcl_decode #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_decode (
		.code_in(code_in_s1),
		.idx_i  (dec_i),
		.idx_j  (dec_j),
		.idx_k  (dec_k),
		.level  (dec_level)
	);

	mcl_parent #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_parent (
		.code_in     (code_in_s1),
		.parent_level(parent_level_s1),
		.code        (par_code),
		.level       (par_level)
	);

	always_comb begin
		result = '0;
		unique case (req_s1)
			REQ_ENCODE: begin
				result.code  = enc_code;
				result.level = enc_level;
			end
			REQ_DECODE: begin
				result.idx_i = dec_i;
				result.idx_j = dec_j;
				result.idx_k = dec_k;
				result.level = dec_level;
			end
			REQ_PARENT: begin
				result.code  = par_code;
				result.level = par_level;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign code_out  = result_s2.code;
	assign out_i     = result_s2.idx_i;
	assign out_j     = result_s2.idx_j;
	assign out_k     = result_s2.idx_k;
	assign out_level = result_s2.level;

endmodule

`default_nettype wire

@@ tb/morton_code_3d_level_codec_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morton_code_3d_level_codec_checker: result checker for the grid code codec
// Watches both channels, predicts the result of every accepted request and
// compares each returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module morton_code_3d_level_codec_checker
	import mcl_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	input  wire   in_ready,
	input  req_t  req_type,
	input  idx_t  coord_i,
	input  idx_t  coord_j,
	input  idx_t  coord_k,
	input  lvl_t  cell_level,
	input  code_t code_in,
	input  lvl_t  parent_level,
	input  wire   out_valid,
	input  wire   out_ready,
	input  code_t code_out,
	input  idx_t  out_i,
	input  idx_t  out_j,
	input  idx_t  out_k,
	input  lvl_t  out_level,
	output int    mismatches,
	output int    outstanding
);

	result_t grid_results_q[$];
	result_t oldest;
	int      err_count = 0;
	int      pending_count = 0;

	assign mismatches  = err_count;
	assign outstanding = pending_count;

	function automatic result_t grid_code_result(input req_t rt, input idx_t ci, input idx_t cj,
			input idx_t ck, input lvl_t cl, input code_t cin, input lvl_t pl);
		result_t r;
		int      lv;
		int      ones;
		int      sh;
		code_t   bits;
		code_t   flag;
		r = '0;
		case (rt)
		REQ_ENCODE: begin
			lv = (cl > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : int'(cl);
			bits = '0;
			for (int b = 0; b < lv; b++) begin
				bits[3*b]   = ci[b];
				bits[3*b+1] = cj[b];
				bits[3*b+2] = ck[b];
			end
			flag = (64'd1 << (63 - 3*lv)) - 64'd1;
			r.code = ((lv == 0) ? 64'd0 : (bits << (64 - 3*lv))) | flag;
			r.level = lvl_t'(lv);
		end
		REQ_DECODE: begin
			ones = 0;
			while (ones < 64 && cin[ones])
				ones++;
			lv = CODE_LEVELS - ones / 3;
			if (lv > MAX_LEVEL_DEF)
				lv = MAX_LEVEL_DEF;
			bits = (lv == 0) ? 64'd0 : (cin >> (64 - 3*lv));
			for (int b = 0; b < lv; b++) begin
				r.idx_i[b] = bits[3*b];
				r.idx_j[b] = bits[3*b+1];
				r.idx_k[b] = bits[3*b+2];
			end
			r.level = lvl_t'(lv);
		end
		REQ_PARENT: begin
			lv = (pl > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : int'(pl);
			sh = 64 - 3*lv;
			flag = (64'd1 << (63 - 3*lv)) - 64'd1;
			r.code = ((lv == 0) ? 64'd0 : ((cin >> sh) << sh)) | flag;
			r.level = lvl_t'(lv);
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				grid_results_q = {grid_results_q, grid_code_result(req_type, coord_i, coord_j,
					coord_k, cell_level, code_in, parent_level)};
			if (out_valid && out_ready) begin
				if (grid_results_q.size() == 0) begin
					$error("result with no pending request: code_out %h", code_out);
					err_count++;
				end else begin
					oldest = grid_results_q.pop_front();
					if (code_out !== oldest.code) begin
						$error("code_out expected %h actual %h", oldest.code, code_out);
						err_count++;
					end
					if (out_i !== oldest.idx_i) begin
						$error("out_i expected %h actual %h", oldest.idx_i, out_i);
						err_count++;
					end
					if (out_j !== oldest.idx_j) begin
						$error("out_j expected %h actual %h", oldest.idx_j, out_j);
						err_count++;
					end
					if (out_k !== oldest.idx_k) begin
						$error("out_k expected %h actual %h", oldest.idx_k, out_k);
						err_count++;
					end
					if (out_level !== oldest.level) begin
						$error("out_level expected %0d actual %0d", oldest.level, out_level);
						err_count++;
					end
				end
			end
			pending_count <= grid_results_q.size();
		end
	end

endmodule

@@ tb/morton_code_3d_level_codec_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morton_code_3d_level_codec_test: testbench top for the grid code codec
// Sends directed and random encode, decode, parent and undefined requests in
// bursts against a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module morton_code_3d_level_codec_test;
	import mcl_pkg::*;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  out_ready = 1'b0;
	req_t  req_type = REQ_ENCODE;
	idx_t  coord_i = '0;
	idx_t  coord_j = '0;
	idx_t  coord_k = '0;
	lvl_t  cell_level = '0;
	code_t code_in = '0;
	lvl_t  parent_level = '0;
	logic  in_ready;
	logic  out_valid;
	code_t code_out;
	idx_t  out_i;
	idx_t  out_j;
	idx_t  out_k;
	lvl_t  out_level;
	int    mismatches;
	int    outstanding;
	logic  long_stall = 1'b0;
	int    burst_left = 0;

	always #1 clk = ~clk;

	morton_code_3d_level_codec dut (.*);

	morton_code_3d_level_codec_checker checker_inst (.*);

	// Builds a well-formed code at level lv with the Morton bits taken from r.
	function automatic code_t level_code(input code_t r, input int lv);
		int sh;
		if (lv == 0)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		sh = 64 - 3*lv;
		return ((r >> sh) << sh) | ((64'd1 << (63 - 3*lv)) - 64'd1);
	endfunction

	function automatic code_t rand_code();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(input req_t rt, input idx_t ci, input idx_t cj, input idx_t ck,
			input lvl_t cl, input code_t cin, input lvl_t pl);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		if (long_stall)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rt;
		coord_i      <= ci;
		coord_j      <= cj;
		coord_k      <= ck;
		cell_level   <= cl;
		code_in      <= cin;
		parent_level <= pl;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		int    cycles;
		int    mode;
		int    span;
		logic  held;
		cycles = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 40);
			repeat (span) begin
				case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
				@(posedge clk);
				cycles++;
			end
			if (!held && cycles > 300) begin
				held = 1'b1;
				long_stall <= 1'b1;
				out_ready <= 1'b0;
				repeat (100) @(posedge clk);
				long_stall <= 1'b0;
			end
		end
	end

	initial begin
		int    kind;
		int    lv;
		int    ones;
		code_t raw;
		req_t  rt;
		lvl_t  cl;
		lvl_t  pl;
		code_t cin;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_ENCODE, '1, '1, '1, 5'd0, rand_code(), 5'd0);
		send_request(REQ_ENCODE, '1, '1, '1, 5'd21, '0, 5'd21);
		send_request(REQ_ENCODE, '0, '0, '0, 5'd21, '1, 5'd31);
		send_request(REQ_ENCODE, 21'h1FFFFF, 21'h0, 21'h155555, 5'd21, '0, '0);
		send_request(REQ_ENCODE, 21'h0AAAAA, 21'h155555, 21'h0F0F0F, 5'd21, '0, '0);
		send_request(REQ_ENCODE, idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
			5'd31, rand_code(), 5'd3);
		send_request(REQ_ENCODE, idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
			5'd22, rand_code(), 5'd9);
		send_request(REQ_ENCODE, 21'h1, 21'h0, 21'h1, 5'd1, '0, '0);
		send_request(REQ_ENCODE, idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
			5'd10, rand_code(), 5'd17);
		send_request(REQ_DECODE, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF, '1);
		send_request(REQ_DECODE, '0, '0, '0, '0, 64'h0, '0);
		send_request(REQ_DECODE, '0, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0);
		send_request(REQ_DECODE, '0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFD, '0);
		send_request(REQ_DECODE, '0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFB, '0);
		send_request(REQ_DECODE, '0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFF7, '0);
		send_request(REQ_DECODE, '0, '0, '0, '0, level_code(rand_code(), 21), '0);
		send_request(REQ_DECODE, '0, '0, '0, '0, level_code(rand_code(), 5), '0);
		send_request(REQ_PARENT, '0, '0, '0, '0, rand_code(), 5'd0);
		send_request(REQ_PARENT, '0, '0, '0, '0, rand_code(), 5'd21);
		send_request(REQ_PARENT, '0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
		send_request(REQ_PARENT, '0, '0, '0, '0, level_code(rand_code(), 12), 5'd3);
		send_request(REQ_PARENT, '0, '0, '0, '0, level_code(rand_code(), 4), 5'd15);
		send_request(req_t'(3), idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
			lvl_t'($urandom), rand_code(), lvl_t'($urandom));
		send_request(req_t'(3), '1, '1, '1, '1, '1, '1);

		repeat (550) begin
			kind = $urandom_range(0, 99);
			raw = rand_code();
			lv = $urandom_range(0, 21);
			cl = ($urandom_range(0, 9) == 0) ? lvl_t'($urandom_range(22, 31))
				: lvl_t'($urandom_range(0, 21));
			pl = ($urandom_range(0, 9) == 0) ? lvl_t'($urandom_range(0, 31))
				: lvl_t'($urandom_range(0, lv));
			if (kind < 30) begin
				rt = REQ_ENCODE;
				cin = raw;
			end else if (kind < 60) begin
				rt = REQ_DECODE;
				if ($urandom_range(0, 9) < 7) begin
					cin = level_code(raw, lv);
				end else begin
					ones = $urandom_range(0, 64);
					cin = (ones == 64) ? '1 : (raw | ((64'd1 << ones) - 64'd1));
				end
			end else if (kind < 95) begin
				rt = REQ_PARENT;
				cin = ($urandom_range(0, 9) == 0) ? raw : level_code(raw, lv);
			end else begin
				rt = req_t'(3);
				cin = raw;
			end
			send_request(rt, idx_t'($urandom), idx_t'($urandom), idx_t'($urandom), cl, cin, pl);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
